>>> rtl/q8dq_pkg.sv
// Package: shared constants and fp16 decode helper for the Q8_0 dequantizer.
`timescale 1ns / 1ps
`default_nettype none
package q8dq_pkg;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] FP32_INF  = 32'h7F80_0000;
    localparam logic [4:0]  EXP_MAX   = 5'h1F;
    localparam logic [7:0]  SUB_BIAS  = 8'd113;
    localparam logic [7:0]  NRM_BIAS  = 8'd112;

    // Decoded fp16 scale, split for the multiply stage
    typedef struct packed {
        logic        sign;
        logic        is_zero;
        logic        is_inf;
        logic        is_nan;
        logic [7:0]  exp;
        logic [10:0] sig;
    } scale_t;

    // Decode an fp16 value; subnormals are normalized with a leading-zero count
    function automatic scale_t decode_half(input logic [15:0] h);
        scale_t      s;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  lz;
        logic [10:0] nm;
        begin
            ex = h[14:10];
            man = h[9:0];
            s.sign = h[15];
            s.is_zero = (ex == 5'd0) && (man == 10'd0);
            s.is_inf = (ex == EXP_MAX) && (man == 10'd0);
            s.is_nan = (ex == EXP_MAX) && (man != 10'd0);
            lz = 4'd0;
            for (int i = 9; i >= 0; i--) begin
                if (man[i] && lz == 4'd0) begin
                    lz = 4'(10 - i);
                end
            end
            nm = {1'b0, man} << lz;
            if (ex == 5'd0) begin
                s.exp = SUB_BIAS - 8'(lz);
                s.sig = {1'b1, nm[9:0]};
            end else begin
                s.exp = 8'(ex) + NRM_BIAS;
                s.sig = {1'b1, man};
            end
            return s;
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/q8dq_mul.sv
// Module: int8 times decoded fp16 scale, exact float32 product.
`timescale 1ns / 1ps
`default_nettype none
module q8dq_mul
    import q8dq_pkg::*;
(
    input  wire scale_t      scale,
    input  wire logic [7:0]  q,
    output logic [31:0]      result
);
    logic        qneg;
    logic [7:0]  qmag;
    logic [18:0] prod;
    logic [4:0]  msb;
    logic [18:0] norm;
    logic [7:0]  rexp;
    logic        rsign;

    always_comb
    begin
        qneg = q[7];
        qmag = qneg ? 8'(-q) : q;
        prod = 19'(qmag) * 19'(scale.sig);
        msb = 5'd0;
        for (int i = 0; i < 19; i++) begin
            if (prod[i]) begin
                msb = 5'(i);
            end
        end
        // product below 2^19; shift leading one to bit 18 (exact, no rounding)
        norm = prod << (5'd18 - msb);
        rexp = scale.exp + 8'(msb) - 8'd10;
        rsign = qneg ^ scale.sign;
        if (scale.is_nan || (scale.is_inf && qmag == 8'd0)) begin
            result = CANON_NAN;
        end else if (scale.is_inf) begin
            result = {rsign, FP32_INF[30:0]};
        end else if (scale.is_zero || qmag == 8'd0) begin
            result = {rsign, 31'd0};
        end else begin
            result = {rsign, rexp, norm[17:0], 5'd0};
        end
    end
endmodule
`default_nettype wire

>>> rtl/q8_0_block_dequantizer.sv
// Top level: Q8_0 block byte stream to float32 elements.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one byte per cycle while in_ready is high. Each block is BLOCK_ELEMENTS+2
// bytes: a little-endian fp16 scale, then signed bytes that each give one float32
// result (byte times scale, exact; NaN results are 0x7FC00000). Scale bytes produce
// no result. restart forces the byte to block offset zero. One register stage
// between input and output: a result appears the cycle after its byte is accepted,
// and with the output taken every cycle the block sustains one byte per cycle; the
// output register alone sets that figure.
module q8_0_block_dequantizer
    import q8dq_pkg::*;
#(
    parameter int BLOCK_ELEMENTS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      value_bits,
    output logic [4:0]       element_index,
    output logic             last_in_block
);
    localparam int PW = $clog2(BLOCK_ELEMENTS + 2);
    localparam logic [PW-1:0] LAST_POS = PW'(BLOCK_ELEMENTS + 1);

    logic [PW-1:0] pos_reg, pos_next, cur_pos;
    logic [7:0]    slow_reg;
    scale_t        scale_reg;
    logic          out_valid_reg;
    logic [31:0]   value_reg;
    logic [4:0]    index_reg;
    logic          last_reg;
    logic [31:0]   prod;
    logic          acc, emit;

    q8dq_mul u_mul (
        .scale  (scale_reg),
        .q      (data_byte),
        .result (prod)
    );

    // accept while output empty or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign acc = in_valid && in_ready;
    assign cur_pos = restart ? '0 : pos_reg;
    assign emit = cur_pos > PW'(1);

    // advance byte position
    always_comb
    begin
        if (cur_pos == LAST_POS) begin
            pos_next = '0;
        end else begin
            pos_next = cur_pos + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0;
            out_valid_reg <= 1'b0;
            slow_reg <= 8'd0;
            scale_reg <= decode_half(16'd0);
        end else begin
            if (acc) begin
                pos_reg <= pos_next;
                if (cur_pos == '0) begin
                    slow_reg <= data_byte;
                end
                if (cur_pos == PW'(1)) begin
                    scale_reg <= decode_half({data_byte, slow_reg});
                end
            end
            if (in_ready) begin
                out_valid_reg <= acc && emit;
            end
        end
    end

    // hold result payload
    always_ff @(posedge clk)
    begin
        if (acc && emit) begin
            value_reg <= prod;
            index_reg <= 5'(cur_pos - PW'(2));
            last_reg <= (cur_pos == LAST_POS);
        end
    end

    assign out_valid = out_valid_reg;
    assign value_bits = value_reg;
    assign element_index = index_reg;
    assign last_in_block = last_reg;
endmodule
`default_nettype wire
